>>> sv/assert_macros.svh
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dssvf_pkg.sv
package dssvf_pkg;

    // Coefficient formats: unsigned, freq and drive Q1.16, damp Q2.16
    localparam int COEF_FRAC  = 16;
    localparam int FREQ_W     = 17;
    localparam int DAMP_W     = 18;
    localparam int DRIVE_W    = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 2'd2;

    localparam logic [FREQ_W-1:0]  FREQ_RESET  = 17'd16384;
    localparam logic [DAMP_W-1:0]  DAMP_RESET  = 18'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 17'd16384;

    // Multiplier operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_B_B     = 3'd1;  // band * band   -> square
    localparam logic [OP_W-1:0] OP_DAMP_B  = 3'd2;  // damp * band   -> notch
    localparam logic [OP_W-1:0] OP_SQ_B    = 3'd3;  // square * band -> cube
    localparam logic [OP_W-1:0] OP_FREQ_B  = 3'd4;  // freq * band   -> low
    localparam logic [OP_W-1:0] OP_DRIVE_C = 3'd5;  // drive * cube  -> cubic term
    localparam logic [OP_W-1:0] OP_FREQ_H  = 3'd6;  // freq * high   -> band

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [DAMP_W-1:0]  damp;
        logic [DRIVE_W-1:0] drive;
    } coef_t;

    typedef struct packed {
        logic            issue_en;
        logic [OP_W-1:0] issue_op;
        logic            load_in;
        logic            load_high;
        logic            capture;
        logic            load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/dssvf_regs.sv
module dssvf_regs
    import dssvf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output coef_t                 coef
);

    coef_t coef_reg;
    coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FREQ:  coef_next.freq  = cfg_data[FREQ_W-1:0];
                REG_DAMP:  coef_next.damp  = cfg_data[DAMP_W-1:0];
                REG_DRIVE: coef_next.drive = cfg_data[DRIVE_W-1:0];
                default:   coef_next = coef_reg;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.freq  <= FREQ_RESET;
            coef_reg.damp  <= DAMP_RESET;
            coef_reg.drive <= DRIVE_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

>>> sv/dssvf_ctrl.sv
`include "assert_macros.svh"

module dssvf_ctrl
    import dssvf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Steps of one filter pass; one multiplier issue per step at most
    localparam logic [2:0] STEP_SQ    = 3'd0;
    localparam logic [2:0] STEP_DAMP  = 3'd1;
    localparam logic [2:0] STEP_CUBE  = 3'd2;
    localparam logic [2:0] STEP_LOW   = 3'd3;
    localparam logic [2:0] STEP_DRIVE = 3'd4;
    localparam logic [2:0] STEP_HIGH  = 3'd5;
    localparam logic [2:0] STEP_BAND  = 3'd6;
    localparam logic [2:0] STEP_LAST  = 3'd7;

    logic [1:0] state_reg, state_next;
    logic [2:0] step_reg,  step_next;
    logic       pass_reg,  pass_next;
    logic       take_in;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        take_in    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                take_in = 1'b1;
            end
            ST_RUN:
            begin
                cmd.issue_en = 1'b1;
                case (step_reg)
                    STEP_SQ:
                    begin
                        cmd.issue_op = OP_B_B;
                        cmd.capture  = pass_reg;  // first pass results are settled
                    end
                    STEP_DAMP:  cmd.issue_op = OP_DAMP_B;
                    STEP_CUBE:  cmd.issue_op = OP_SQ_B;
                    STEP_LOW:   cmd.issue_op = OP_FREQ_B;
                    STEP_DRIVE: cmd.issue_op = OP_DRIVE_C;
                    STEP_HIGH:
                    begin
                        cmd.issue_en  = 1'b0;
                        cmd.load_high = 1'b1;
                    end
                    STEP_BAND:  cmd.issue_op = OP_FREQ_H;
                    default:    cmd.issue_en = 1'b0;  // band write-back
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST)
                begin
                    if (!pass_reg)
                        pass_next = 1'b1;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    take_in      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = STEP_SQ;
            end
        endcase

        if (take_in && in_valid)
        begin
            cmd.load_in = 1'b1;
            state_next  = ST_RUN;
            step_next   = STEP_SQ;
            pass_next   = 1'b0;
        end

        in_stall = !take_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_SQ;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    `ASSERT_NEXT(a_finish_holds, clk, rst_n, (state_reg == ST_FINISH) && !status.out_free, state_reg == ST_FINISH, "result lost while output busy")
    `ASSERT_SAME(a_step_idle, clk, rst_n, state_reg != ST_RUN, step_reg == STEP_SQ, "step counter not parked")
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, (state_reg == ST_RUN) && (step_reg == STEP_SQ) && !pass_reg, "accepted beat did not start a run")

endmodule

>>> sv/dssvf_dp.sv
module dssvf_dp
    import dssvf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  coef_t                         coef,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          last_in_block,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] lowpass_out,
    output logic signed [SAMPLE_BITS-1:0] highpass_out,
    output logic signed [SAMPLE_BITS-1:0] bandpass_out,
    output logic                          block_end
);

    localparam int S      = SAMPLE_BITS;
    localparam int FRAC_W = S - 1;
    localparam int IW     = S + 4;            // integrators Q5.F
    localparam int NW     = IW + 3;           // notch
    localparam int HW     = IW + 4;           // high
    localparam int SQW    = IW + 5;           // square, never negative
    localparam int CW     = IW + 9;           // cube and cubic term
    localparam int AW     = IW + 8;           // multiplier operand a (magnitude)
    localparam int BW     = (IW > DAMP_W) ? IW : DAMP_W;
    localparam int PW     = AW + BW;
    localparam int RW     = IW + 10;          // shifted signed product

    logic signed [IW-1:0]  low_reg, band_reg;
    logic signed [S-1:0]   x_reg;
    logic                  last_reg;
    logic signed [NW-1:0]  notch_reg;
    logic signed [HW-1:0]  high_reg;
    logic signed [SQW-1:0] sq_reg;
    logic signed [CW-1:0]  cube_reg, p4_reg;
    logic signed [IW-1:0]  low1_reg, band1_reg;
    logic signed [HW-1:0]  high1_reg;

    logic [PW-1:0]         prod_reg;
    logic                  neg_reg, shf_reg;
    logic [OP_W-1:0]       op_reg;
    logic                  wb_reg;

    logic                  out_valid_reg;
    logic signed [S-1:0]   lowpass_reg, highpass_reg, bandpass_reg;
    logic                  block_end_reg;

    logic [IW-1:0]         band_mag;
    logic [HW-1:0]         high_mag;
    logic [CW-1:0]         cube_mag;
    logic [AW-1:0]         mul_a;
    logic [BW-1:0]         mul_b;
    logic                  mul_neg, mul_shf;
    logic [PW-1:0]         prod_next;
    logic [PW-1:0]         shifted;
    logic [RW-1:0]         res_mag;
    logic signed [RW-1:0]  res;
    logic signed [RW:0]    low_sum, band_sum;

    function automatic logic signed [IW-1:0] sat_integ(input logic signed [RW:0] v);
        if (&v[RW:IW-1] || ~|v[RW:IW-1])
            return v[IW-1:0];
        return {v[RW], {(IW-1){~v[RW]}}};
    endfunction

    // (a + b) / 2 toward zero, clamped to the sample width
    function automatic logic signed [S-1:0] avg_sat(input logic signed [HW-1:0] a,
                                                    input logic signed [HW-1:0] b);
        logic [HW:0] sum;
        logic [HW:0] adj;
        logic [HW:0] half;
        sum  = {a[HW-1], a} + {b[HW-1], b};
        adj  = sum + {{HW{1'b0}}, sum[HW]};
        half = {adj[HW], adj[HW:1]};
        if (&half[HW:S-1] || ~|half[HW:S-1])
            return half[S-1:0];
        return {half[HW], {(S-1){~half[HW]}}};
    endfunction

    assign band_mag = band_reg[IW-1] ? (~band_reg + 1'b1) : band_reg;
    assign high_mag = high_reg[HW-1] ? (~high_reg + 1'b1) : high_reg;
    assign cube_mag = cube_reg[CW-1] ? (~cube_reg + 1'b1) : cube_reg;

    // operand select for the shared sign-magnitude multiplier
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_shf = 1'b0;
        case (cmd.issue_op)
            OP_B_B:
            begin
                mul_a   = AW'(band_mag);
                mul_b   = BW'(band_mag);
                mul_shf = 1'b1;
            end
            OP_DAMP_B:
            begin
                mul_a   = AW'(band_mag);
                mul_b   = BW'(coef.damp);
                mul_neg = band_reg[IW-1];
            end
            OP_SQ_B:
            begin
                mul_a   = AW'(sq_reg[IW+3:0]);
                mul_b   = BW'(band_mag);
                mul_neg = band_reg[IW-1];
                mul_shf = 1'b1;
            end
            OP_FREQ_B:
            begin
                mul_a   = AW'(band_mag);
                mul_b   = BW'(coef.freq);
                mul_neg = band_reg[IW-1];
            end
            OP_DRIVE_C:
            begin
                mul_a   = cube_mag[AW-1:0];
                mul_b   = BW'(coef.drive);
                mul_neg = cube_reg[CW-1];
            end
            OP_FREQ_H:
            begin
                mul_a   = AW'(high_mag);
                mul_b   = BW'(coef.freq);
                mul_neg = high_reg[HW-1];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // truncate the magnitude, then restore sign: rounds toward zero
    assign shifted  = shf_reg ? (prod_reg >> FRAC_W) : (prod_reg >> COEF_FRAC);
    assign res_mag  = shifted[RW-1:0];
    assign res      = neg_reg ? -$signed(res_mag) : $signed(res_mag);

    assign low_sum  = {{(RW+1-IW){low_reg[IW-1]}}, low_reg} + {res[RW-1], res};
    assign band_sum = {{(RW+1-IW){band_reg[IW-1]}}, band_reg} + {res[RW-1], res}
                    - {{(RW+1-CW){p4_reg[CW-1]}}, p4_reg};

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= '0;
            band_reg      <= '0;
            wb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wb_reg <= cmd.issue_en;
            if (wb_reg && op_reg == OP_FREQ_B)
                low_reg <= sat_integ(low_sum);
            if (wb_reg && op_reg == OP_FREQ_H)
                band_reg <= sat_integ(band_sum);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue_en)
        begin
            prod_reg <= prod_next;
            neg_reg  <= mul_neg;
            shf_reg  <= mul_shf;
            op_reg   <= cmd.issue_op;
        end
        if (cmd.load_in)
        begin
            x_reg    <= sample_in;
            last_reg <= last_in_block;
        end
        if (wb_reg)
        begin
            case (op_reg)
                OP_B_B:     sq_reg    <= res[SQW-1:0];
                OP_DAMP_B:  notch_reg <= {{(NW-S){x_reg[S-1]}}, x_reg} - res[NW-1:0];
                OP_SQ_B:    cube_reg  <= res[CW-1:0];
                OP_DRIVE_C: p4_reg    <= res[CW-1:0];
                default:    sq_reg    <= sq_reg;
            endcase
        end
        if (cmd.load_high)
            high_reg <= {{(HW-NW){notch_reg[NW-1]}}, notch_reg}
                      - {{(HW-IW){low_reg[IW-1]}}, low_reg};
        if (cmd.capture)
        begin
            low1_reg  <= low_reg;
            band1_reg <= band_reg;
            high1_reg <= high_reg;
        end
        if (cmd.load_out)
        begin
            lowpass_reg   <= avg_sat({{(HW-IW){low1_reg[IW-1]}}, low1_reg},
                                     {{(HW-IW){low_reg[IW-1]}}, low_reg});
            highpass_reg  <= avg_sat(high1_reg, high_reg);
            bandpass_reg  <= avg_sat({{(HW-IW){band1_reg[IW-1]}}, band1_reg},
                                     {{(HW-IW){band_reg[IW-1]}}, band_reg});
            block_end_reg <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lowpass_out  = lowpass_reg;
    assign highpass_out = highpass_reg;
    assign bandpass_out = bandpass_reg;
    assign block_end    = block_end_reg;

endmodule

>>> sv/double_sampled_state_variable_filter.sv
// Channel   Handshake               Beat contents
// -------   ---------------------   ----------------------------------------------
// cfg       cfg_valid / cfg_ready   cfg_index (0 freq, 1 damp, 2 drive), cfg_data
// in        in_valid / in_stall     sample_in (Q1.F), last_in_block
// out       out_valid / out_stall   lowpass_out, highpass_out, bandpass_out, block_end
//
// Each sample runs two filter passes of 8 steps each on the single shared
// sign-magnitude multiplier (six products per pass), then the passes are
// averaged into the output register.
// Reset clears both integrators and loads the coefficient defaults.
// A result waits in the output register under out_stall; the next sample is
// taken meanwhile, and its averaging step waits until the register is free.
// cfg_ready is always high; writes belong in idle time between samples.
module double_sampled_state_variable_filter
    import dssvf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          last_in_block,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] lowpass_out,
    output logic signed [SAMPLE_BITS-1:0] highpass_out,
    output logic signed [SAMPLE_BITS-1:0] bandpass_out,
    output logic                          block_end
);

    coef_t      coef;
    dp_cmd_t    cmd;
    dp_status_t status;

    // coefficient registers, written by software
    dssvf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // step sequencer: issues at most one multiply per step, two passes per sample
    dssvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // integrators, shared multiplier, averaging and output register
    dssvf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .coef          (coef),
        .cmd           (cmd),
        .status        (status),
        .sample_in     (sample_in),
        .last_in_block (last_in_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lowpass_out   (lowpass_out),
        .highpass_out  (highpass_out),
        .bandpass_out  (bandpass_out),
        .block_end     (block_end)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dssvf_pkg::*;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;   // Q1.F samples
    localparam int INTEG_BITS  = SAMPLE_BITS + 4;   // Q5.F integrators
    localparam int DRAIN_WAIT  = 40;                // longer than one sample takes
    localparam longint SAMPLE_MAX = (64'sd1 <<< FRAC_BITS) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 <<< FRAC_BITS);

    // Not a register: writes to this index must leave the coefficients alone.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // In-range upper bounds of the coefficients (software clamps).
    localparam int FREQ_TOP  = 92682;
    localparam int DAMP_TOP  = 131072;
    localparam int DRIVE_TOP = 65536;

    // Shapes of the random sample streams.
    typedef enum int {WAVE_NOISE, WAVE_QUIET, WAVE_SQUARE, WAVE_RAIL, WAVE_RAMP} wave_e;

    // One averaged result beat, as the block should present it.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] low;
        logic signed [SAMPLE_BITS-1:0] high;
        logic signed [SAMPLE_BITS-1:0] band;
        logic                          last;
    } svf_result_t;

    logic clk;
    logic rst_n;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in_block;

    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] lowpass_out;
    logic signed [SAMPLE_BITS-1:0] highpass_out;
    logic signed [SAMPLE_BITS-1:0] bandpass_out;
    logic                          block_end;

    double_sampled_state_variable_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_in     (sample_in),
        .last_in_block (last_in_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lowpass_out   (lowpass_out),
        .highpass_out  (highpass_out),
        .bandpass_out  (bandpass_out),
        .block_end     (block_end)
    );

    // ------------------------------------------------------------------
    // Filter predictor: coefficients and integrators mirrored here.
    // ------------------------------------------------------------------
    longint freq_c;
    longint damp_c;
    longint drive_c;
    longint low_acc;
    longint band_acc;

    svf_result_t filtered_q[$];   // expected output beats, oldest first
    int          errors;

    // Control knobs for the idle generators.
    bit tx_idle_en;
    bit rx_idle_en;
    int hold_cycles;              // >0 asks the receiver for one long hold-off

    // Exact product, shifted right, rounded toward zero (sign-magnitude).
    // All magnitude products here stay below 2^59, so they fit in 64 bits.
    function automatic longint scaled_product(longint a, longint b, int sh);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        m  = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One Chamberlin pass; updates the integrators, returns the highpass value.
    // The cubic term uses band as it stood at the start of the pass.
    function automatic longint svf_pass(longint x);
        longint band;
        longint notch;
        longint high;
        longint cube;
        band    = band_acc;
        notch   = x - scaled_product(damp_c, band, COEF_FRAC);
        low_acc = clamp(low_acc + scaled_product(freq_c, band, COEF_FRAC), INTEG_BITS);
        high    = notch - low_acc;
        cube    = scaled_product(scaled_product(band, band, FRAC_BITS), band, FRAC_BITS);
        band_acc = clamp(band + scaled_product(freq_c, high, COEF_FRAC)
                         - scaled_product(drive_c, cube, COEF_FRAC), INTEG_BITS);
        return high;
    endfunction

    // Two passes per sample; outputs are the averages, truncated then saturated.
    function automatic svf_result_t filter_sample(logic signed [SAMPLE_BITS-1:0] s,
                                                  logic last);
        longint x;
        longint low1;
        longint band1;
        longint high1;
        longint high2;
        svf_result_t r;
        x     = s;
        high1 = svf_pass(x);
        low1  = low_acc;
        band1 = band_acc;
        high2 = svf_pass(x);
        r.low  = SAMPLE_BITS'(clamp((low1 + low_acc) / 2, SAMPLE_BITS));
        r.high = SAMPLE_BITS'(clamp((high1 + high2) / 2, SAMPLE_BITS));
        r.band = SAMPLE_BITS'(clamp((band1 + band_acc) / 2, SAMPLE_BITS));
        r.last = last;
        return r;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop; a correct run needs well under a fifth of this.
    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: drives out_stall on the falling edge.
    // ------------------------------------------------------------------
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                // long hold-off so the block backs up and stalls its input
                out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 99) < 12) begin
                n = idle_len();
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted output beat against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        svf_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: output beat with nothing expected, actual %0d %0d %0d %0b",
                         $time, lowpass_out, highpass_out, bandpass_out, block_end);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                check_field("lowpass_out",  want.low,  lowpass_out);
                check_field("highpass_out", want.high, highpass_out);
                check_field("bandpass_out", want.band, bandpass_out);
                check_field("block_end",    want.last, block_end);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers. Each is entered and left on a falling edge.
    // send_sample leaves in_valid high; the next send or wait_drained settles it,
    // so back-to-back beats never see valid dropped and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        sample_in     <= s;
        last_in_block <= last;
        do @(posedge clk); while (in_stall);
        filtered_q.push_back(filter_sample(s, last));
        @(negedge clk);
    endtask

    // Stop sending and wait for every predicted beat to come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    // Only called with the block idle (after wait_drained).
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_FREQ:  freq_c  = val[FREQ_W-1:0];
            REG_DAMP:  damp_c  = val[DAMP_W-1:0];
            REG_DRIVE: drive_c = val[DRIVE_W-1:0];
            default:   ;   // out-of-range index: ignored
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_coeffs(input int f, input int d, input int g);
        write_reg(REG_FREQ,  CFG_DATA_W'(f));
        write_reg(REG_DAMP,  CFG_DATA_W'(d));
        write_reg(REG_DRIVE, CFG_DATA_W'(g));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients: rails, zero, +-1 LSB, alternating bit patterns.
    task automatic test_reset_defaults();
        send_sample(0, 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b1);
        send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
        send_sample(1, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(24'hA5A5A5, 1'b0);
        send_sample(24'h5A5A5A, 1'b1);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(0, 1'b1);
        wait_drained();
    endtask

    // Coefficient corners: all zero, in-range maxima, raw all-ones (above range),
    // and a write to the unused index. Rails drive integrators and outputs
    // into saturation.
    task automatic test_coeff_extremes();
        write_coeffs(0, 0, 0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b1);
        wait_drained();

        write_coeffs(FREQ_TOP, DAMP_TOP, DRIVE_TOP);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b1);
        wait_drained();

        write_coeffs((1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1);
        write_reg(REG_NONE, '0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MIN), 1'b0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), 1'b0);
        send_sample(0, 1'b1);
        wait_drained();
    endtask

    // Backpressure: long receiver hold-off while the sender keeps offering beats,
    // then a full drain before the next burst.
    task automatic test_pressure();
        write_coeffs(20000, 60000, 16384);
        tx_idle_en  = 1'b0;
        hold_cycles = 250;
        for (int i = 0; i < 12; i++)
            send_sample(SAMPLE_BITS'($urandom), 1'(i == 11));
        wait_drained();          // sender pauses until everything is out
        tx_idle_en = 1'b1;
        for (int i = 0; i < 6; i++)
            send_sample(SAMPLE_BITS'($urandom), 1'(i == 5));
        wait_drained();
    endtask

    // Random coefficient pick: zero, in-range top, raw 18-bit, or in range.
    function automatic int pick_coeff(int top);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return top;
        if (roll == 2)
            return $urandom_range(0, (1 << CFG_DATA_W) - 1);
        return $urandom_range(0, top);
    endfunction

    // Runs of shaped signals with block-end marks every 1..32 samples.
    task automatic play_segment(input int count);
        wave_e kind;
        int run_left;
        int block_left;
        int amp;
        int period;
        int ph;
        int step;
        logic signed [SAMPLE_BITS-1:0] ramp;
        logic signed [SAMPLE_BITS-1:0] s;
        run_left   = 0;
        block_left = 0;
        kind       = WAVE_NOISE;
        amp        = 1;
        period     = 2;
        ph         = 0;
        step       = 0;
        ramp       = '0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                kind     = wave_e'($urandom_range(0, 4));
                run_left = $urandom_range(8, 48);
                amp      = $urandom_range(1, int'(SAMPLE_MAX));
                period   = $urandom_range(2, 40);
                ph       = 0;
                step     = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                ramp     = SAMPLE_BITS'($urandom);
            end
            run_left--;
            case (kind)
                WAVE_NOISE:  s = SAMPLE_BITS'($urandom);
                WAVE_QUIET:  s = SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
                WAVE_SQUARE: s = (ph < period / 2) ? SAMPLE_BITS'(amp) : SAMPLE_BITS'(-amp);
                WAVE_RAIL:   s = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX)
                                                      : SAMPLE_BITS'(SAMPLE_MIN);
                default:     s = ramp;   // wraps at the 24-bit boundary
            endcase
            ph   = (ph + 1) % period;
            ramp = ramp + SAMPLE_BITS'(step);
            if (block_left == 0)
                block_left = $urandom_range(1, 32);
            block_left--;
            send_sample(s, 1'(block_left == 0));
        end
    endtask

    // Random phases: new coefficients each phase, every fourth phase without idles.
    task automatic test_random_streams();
        for (int p = 0; p < 10; p++) begin
            write_coeffs(pick_coeff(FREQ_TOP), pick_coeff(DAMP_TOP), pick_coeff(DRIVE_TOP));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, CFG_DATA_W'($urandom));
            tx_idle_en = (p % 4 != 3);
            rx_idle_en = (p % 4 != 3);
            play_segment(95);
            wait_drained();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_in     = '0;
        last_in_block = 1'b0;
        errors        = 0;
        hold_cycles   = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        freq_c        = FREQ_RESET;
        damp_c        = DAMP_RESET;
        drive_c       = DRIVE_RESET;
        low_acc       = 0;
        band_acc      = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_coeff_extremes();
        test_pressure();
        test_random_streams();

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/dssvf_pkg.sv
sv/dssvf_regs.sv
sv/dssvf_ctrl.sv
sv/dssvf_dp.sv
sv/double_sampled_state_variable_filter.sv
tb/tb_top.sv
